// ----- hdl/tec_pkg.sv -----
// ----------------------------------------------------------------------------
// tec_pkg
// Types and constants shared by the thermal erosion cell kernel.
// ----------------------------------------------------------------------------
package tec_pkg;

    localparam int HW        = 31;
    localparam int DIRS      = 8;
    localparam int FRAC_BITS = 16;
    localparam int QW        = 30;
    localparam int SW        = 34;
    localparam int NUMW      = 61;
    localparam int AW        = 3;

    localparam logic [HW-1:0] TALUS_RESET   = HW'((17 << FRAC_BITS) / 1000);
    localparam logic [30:0]   SQRT2_Q30     = 31'd1518500250;
    localparam logic [29:0]   INV_SQRT2_Q30 = 30'd759250125;
    localparam logic [31:0]   RECIP3        = 32'hAAAAAAAB;

    localparam logic REG_TALUS = 1'b0;

    typedef logic [HW-1:0] height_t;

    typedef struct packed {
        height_t center_height;
        height_t height_nw;
        height_t height_n;
        height_t height_ne;
        height_t height_e;
        height_t height_se;
        height_t height_s;
        height_t height_sw;
        height_t height_w;
    } tec_in_t;

    typedef struct packed {
        height_t remaining_height;
        height_t flow_nw;
        height_t flow_n;
        height_t flow_ne;
        height_t flow_e;
        height_t flow_se;
        height_t flow_s;
        height_t flow_sw;
        height_t flow_w;
    } tec_out_t;

endpackage

// ----- hdl/tec_intf.sv -----
// ----------------------------------------------------------------------------
// tec_intf
// Valid/ready stream interfaces for the stencil input and the result output.
// ----------------------------------------------------------------------------
interface tec_in_if;
    logic            valid;
    logic            ready;
    tec_pkg::tec_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tec_out_if;
    logic             valid;
    logic             ready;
    tec_pkg::tec_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/thermal_erosion_cell_kernel.sv -----
// ----------------------------------------------------------------------------
// thermal_erosion_cell_kernel
// Eight-neighbour talus stencil: remaining height and outflow per neighbour.
//
// One stencil (center and eight neighbour heights) is taken per transfer on
// in_ch, and exactly one result leaves on out_ch, in order. The block takes a
// new stencil every cycle while out_ch is not stalled. The pipeline holds six
// stages of difference, threshold, weighting and summing, then a 30-stage
// divider that forms one quotient bit per stage in eight lanes at once.
// The talus threshold is written over the APB port at address 0 and reads
// back there; write it only while the pipeline is empty.
// Reset empties the pipeline and loads the threshold with 0.017 in Q15.16.
// When out_ch is stalled with a result waiting, the whole pipeline holds and
// in_ch.ready drops; no transfer is lost or repeated.
// ----------------------------------------------------------------------------
module thermal_erosion_cell_kernel (
    input  logic                   clk,
    input  logic                   rst_n,
    tec_in_if.sink                 in_ch,
    tec_out_if.source              out_ch,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [tec_pkg::AW-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import tec_pkg::*;

    height_t thr_reg;
    height_t nb [DIRS];
    logic    en;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TALUS) ? {1'b0, thr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= TALUS_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_TALUS)
        begin
            thr_reg <= pwdata[HW-1:0];
        end
    end

    assign nb[0] = in_ch.data.height_nw;
    assign nb[1] = in_ch.data.height_n;
    assign nb[2] = in_ch.data.height_ne;
    assign nb[3] = in_ch.data.height_e;
    assign nb[4] = in_ch.data.height_se;
    assign nb[5] = in_ch.data.height_s;
    assign nb[6] = in_ch.data.height_sw;
    assign nb[7] = in_ch.data.height_w;

    logic out_valid_reg;
    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // Stage 1: drops.
    logic    s1_valid_reg;
    height_t s1_center_reg;
    height_t s1_thr_reg;
    height_t s1_drop_reg [DIRS];

    // Stage 2: differences to threshold, scaled threshold, pair maxima.
    logic        s2_valid_reg;
    height_t     s2_center_reg;
    height_t     s2_drop_reg [DIRS];
    logic [31:0] s2_diff_reg [DIRS];
    logic [61:0] s2_thrp_reg;
    height_t     s2_max_reg [4];

    // Stage 3: qualification, diagonal products, largest drop.
    logic        s3_valid_reg;
    height_t     s3_center_reg;
    logic        s3_q_reg [DIRS];
    logic [60:0] s3_prod_reg [DIRS];
    height_t     s3_max_reg;

    // Stage 4: weights and scaled largest drop.
    logic        s4_valid_reg;
    height_t     s4_center_reg;
    height_t     s4_w_reg [DIRS];
    logic [62:0] s4_amtp_reg;

    // Stage 5: pair sums.
    logic        s5_valid_reg;
    height_t     s5_center_reg;
    height_t     s5_w_reg [DIRS];
    logic [31:0] s5_ps_reg [4];
    logic [QW-1:0] s5_amt_reg;

    // Stage 6: weight sum and numerators.
    logic          s6_valid_reg;
    height_t       s6_rh_reg;
    logic [SW-1:0] s6_wsum_reg;
    logic [NUMW-1:0] s6_num_reg [DIRS];
    logic [QW-1:0] s6_amt_reg;
    logic          s6_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_ch.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    logic [SW-1:0] wsum_next;
    assign wsum_next = SW'(s5_ps_reg[0]) + SW'(s5_ps_reg[1])
                     + SW'(s5_ps_reg[2]) + SW'(s5_ps_reg[3]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_center_reg <= in_ch.data.center_height;
            s1_thr_reg    <= thr_reg;
            for (int k = 0; k < DIRS; k++)
            begin
                s1_drop_reg[k] <= (in_ch.data.center_height > nb[k])
                                  ? in_ch.data.center_height - nb[k] : '0;
            end

            s2_center_reg <= s1_center_reg;
            s2_thrp_reg   <= 62'(s1_thr_reg) * 62'(SQRT2_Q30);
            for (int k = 0; k < DIRS; k++)
            begin
                s2_drop_reg[k] <= s1_drop_reg[k];
                s2_diff_reg[k] <= {1'b0, s1_drop_reg[k]} - {1'b0, s1_thr_reg};
            end
            for (int p = 0; p < 4; p++)
            begin
                s2_max_reg[p] <= (s1_drop_reg[2*p] > s1_drop_reg[2*p+1])
                                 ? s1_drop_reg[2*p] : s1_drop_reg[2*p+1];
            end

            s3_center_reg <= s2_center_reg;
            s3_max_reg    <= (((s2_max_reg[0] > s2_max_reg[1]) ? s2_max_reg[0] : s2_max_reg[1])
                           > ((s2_max_reg[2] > s2_max_reg[3]) ? s2_max_reg[2] : s2_max_reg[3]))
                           ? ((s2_max_reg[0] > s2_max_reg[1]) ? s2_max_reg[0] : s2_max_reg[1])
                           : ((s2_max_reg[2] > s2_max_reg[3]) ? s2_max_reg[2] : s2_max_reg[3]);
            for (int k = 0; k < DIRS; k++)
            begin
                if ((k % 2) == 0)
                begin
                    s3_q_reg[k]    <= {1'b0, s2_drop_reg[k], 30'd0} > s2_thrp_reg;
                    s3_prod_reg[k] <= 61'(s2_diff_reg[k][HW-1:0]) * 61'(INV_SQRT2_Q30);
                end
                else
                begin
                    s3_q_reg[k]    <= !s2_diff_reg[k][31] && (s2_diff_reg[k] != 32'd0);
                    s3_prod_reg[k] <= {30'd0, s2_diff_reg[k][HW-1:0]};
                end
            end

            s4_center_reg <= s3_center_reg;
            s4_amtp_reg   <= 63'(s3_max_reg) * 63'(RECIP3);
            for (int k = 0; k < DIRS; k++)
            begin
                if (!s3_q_reg[k])
                    s4_w_reg[k] <= '0;
                else if ((k % 2) == 0)
                    s4_w_reg[k] <= s3_prod_reg[k][60:30];
                else
                    s4_w_reg[k] <= s3_prod_reg[k][HW-1:0];
            end

            s5_center_reg <= s4_center_reg;
            s5_amt_reg    <= s4_amtp_reg[62:33];
            for (int k = 0; k < DIRS; k++)
            begin
                s5_w_reg[k] <= s4_w_reg[k];
            end
            for (int p = 0; p < 4; p++)
            begin
                s5_ps_reg[p] <= {1'b0, s4_w_reg[2*p]} + {1'b0, s4_w_reg[2*p+1]};
            end

            s6_wsum_reg <= wsum_next;
            s6_zero_reg <= (wsum_next == '0);
            s6_amt_reg  <= s5_amt_reg;
            s6_rh_reg   <= (wsum_next == '0) ? s5_center_reg
                                             : s5_center_reg - {1'b0, s5_amt_reg};
            for (int k = 0; k < DIRS; k++)
            begin
                s6_num_reg[k] <= NUMW'(s5_amt_reg) * NUMW'(s5_w_reg[k]);
            end
        end
    end

    // Divider: one quotient bit per stage, eight lanes sharing the divisor.
    logic          dv_valid_reg [QW];
    logic [SW-1:0] dv_rem_reg   [QW][DIRS];
    logic [QW-1:0] dv_low_reg   [QW][DIRS];
    logic [SW-1:0] dv_wsum_reg  [QW];
    height_t       dv_rh_reg    [QW];
    logic [QW-1:0] dv_amt_reg   [QW];
    logic          dv_zero_reg  [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic          src_valid;
        logic [SW-1:0] src_rem [DIRS];
        logic [QW-1:0] src_low [DIRS];
        logic [SW-1:0] src_wsum;
        height_t       src_rh;
        logic [QW-1:0] src_amt;
        logic          src_zero;

        if (j == 0)
        begin : g_first
            assign src_valid = s6_valid_reg;
            assign src_wsum  = s6_wsum_reg;
            assign src_rh    = s6_rh_reg;
            assign src_amt   = s6_amt_reg;
            assign src_zero  = s6_zero_reg;
            for (genvar k = 0; k < DIRS; k++)
            begin : g_lane
                assign src_rem[k] = SW'(s6_num_reg[k][NUMW-1:QW]);
                assign src_low[k] = s6_num_reg[k][QW-1:0];
            end
        end
        else
        begin : g_next
            assign src_valid = dv_valid_reg[j-1];
            assign src_wsum  = dv_wsum_reg[j-1];
            assign src_rh    = dv_rh_reg[j-1];
            assign src_amt   = dv_amt_reg[j-1];
            assign src_zero  = dv_zero_reg[j-1];
            for (genvar k = 0; k < DIRS; k++)
            begin : g_lane
                assign src_rem[k] = dv_rem_reg[j-1][k];
                assign src_low[k] = dv_low_reg[j-1][k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j] <= 1'b0;
            else if (en)
                dv_valid_reg[j] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            logic [SW:0] t;
            logic        ge;
            if (en)
            begin
                dv_wsum_reg[j] <= src_wsum;
                dv_rh_reg[j]   <= src_rh;
                dv_amt_reg[j]  <= src_amt;
                dv_zero_reg[j] <= src_zero;
                for (int k = 0; k < DIRS; k++)
                begin
                    t  = {src_rem[k], src_low[k][QW-1]};
                    ge = t >= {1'b0, src_wsum};
                    dv_rem_reg[j][k] <= ge ? SW'(t - {1'b0, src_wsum}) : SW'(t);
                    dv_low_reg[j][k] <= {src_low[k][QW-2:0], ge};
                end
            end
        end
    end

    height_t flow [DIRS];
    for (genvar k = 0; k < DIRS; k++)
    begin : g_flow
        assign flow[k] = dv_zero_reg[QW-1] ? '0 : HW'(dv_low_reg[QW-1][k]);
    end

    assign out_valid_reg                = dv_valid_reg[QW-1];
    assign out_ch.valid                 = out_valid_reg;
    assign out_ch.data.remaining_height = dv_rh_reg[QW-1];
    assign out_ch.data.flow_nw          = flow[0];
    assign out_ch.data.flow_n           = flow[1];
    assign out_ch.data.flow_ne          = flow[2];
    assign out_ch.data.flow_e           = flow[3];
    assign out_ch.data.flow_se          = flow[4];
    assign out_ch.data.flow_s           = flow[5];
    assign out_ch.data.flow_sw          = flow[6];
    assign out_ch.data.flow_w           = flow[7];

    // A stalled pipeline keeps the valid bits of stage 1, stage 6 and the output in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s1_valid_reg) && $stable(s6_valid_reg) && $stable(out_valid_reg))
        else $error("pipeline moved during a stall");

    // The NW, N and E outflows do not exceed the amount leaving the cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (flow[0] <= HW'(dv_amt_reg[QW-1]))
                       && (flow[1] <= HW'(dv_amt_reg[QW-1]))
                       && (flow[3] <= HW'(dv_amt_reg[QW-1])))
        else $error("outflow larger than amount leaving");

    // The zero flag is set only by a zero weight sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        s6_valid_reg && s6_zero_reg |-> s6_wsum_reg == '0)
        else $error("zero flag without zero weight sum");

endmodule
